@@ hdl/qte_pkg.sv @@
// ----------------------------------------------------------------------------
// qte_pkg - shared types and constants
// Widths, request side-band struct, CORDIC vector type, arctangent table.
// ----------------------------------------------------------------------------
package qte_pkg;

   localparam int QW        = 16;  // quaternion part width, Q2.14
   localparam int AW        = 16;  // binary angle width
   localparam int STEPS     = 16;  // CORDIC iterations
   localparam int CW        = 37;  // CORDIC datapath width
   localparam int NW        = 33;  // squared norm width (unsigned)
   localparam int TRW       = 34;  // raw pitch term width (signed)
   localparam int TW        = 30;  // clamped pitch term width (signed)
   localparam int DIV_STEPS = 28;  // quotient bits of the pitch division
   localparam int SQ_STEPS  = 29;  // root bits of the square root
   localparam int SQW       = 58;  // square root working width
   localparam int RW        = 29;  // root width

   localparam logic signed [CW-1:0]  ONE_CW  = CW'(1 <<< 28);
   localparam logic signed [TRW-1:0] ONE_TRW = TRW'(1 <<< 28);
   localparam logic signed [TW-1:0]  ONE_TW  = TW'(1 <<< 28);
   localparam logic [31:0]           ANG_PI  = 32'h8000_0000;

   typedef struct packed {
      logic                 degen;
      logic signed [CW-1:0] roll_y;
      logic signed [CW-1:0] roll_x;
      logic signed [CW-1:0] yaw_y;
      logic signed [CW-1:0] yaw_x;
   } side_type;

   typedef struct packed {
      side_type              side;
      logic                  en;
      logic [NW-1:0]         n;
      logic signed [TRW-1:0] t;
   } front_type;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic [31:0]          ang;
      logic                 zero;
   } vec_type;

   // atan(2^-i), 2^32 = 2 pi
   function automatic logic [31:0] atan_entry(input logic [4:0] i);
      logic [31:0] r;
      case (i)
         5'd0:  r = 32'h20000000;
         5'd1:  r = 32'h12E4051E;
         5'd2:  r = 32'h09FB385B;
         5'd3:  r = 32'h051111D4;
         5'd4:  r = 32'h028B0D43;
         5'd5:  r = 32'h0145D7E1;
         5'd6:  r = 32'h00A2F61E;
         5'd7:  r = 32'h00517C55;
         5'd8:  r = 32'h0028BE53;
         5'd9:  r = 32'h00145F2F;
         5'd10: r = 32'h000A2F98;
         5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6;
         5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2FA;
         5'd15: r = 32'h0000517D;
         5'd16: r = 32'h000028BE;
         5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A30;
         5'd19: r = 32'h00000518;
         5'd20: r = 32'h0000028C;
         5'd21: r = 32'h00000146;
         5'd22: r = 32'h000000A3;
         5'd23: r = 32'h00000051;
         5'd24: r = 32'h00000029;
         5'd25: r = 32'h00000014;
         5'd26: r = 32'h0000000A;
         5'd27: r = 32'h00000005;
         5'd28: r = 32'h00000003;
         5'd29: r = 32'h00000001;
         5'd30: r = 32'h00000001;
         default: r = 32'h00000000;
      endcase
      return r;
   endfunction

   // round half up to AW bits, wrapping
   function automatic logic [AW-1:0] round_angle(input logic [31:0] a);
      logic [31:0] s;
      s = a + (32'd1 << (31 - AW));
      return s[31 -: AW];
   endfunction

endpackage

@@ hdl/qte_front.sv @@
// ----------------------------------------------------------------------------
// qte_front - products and sums
// Ten part products, then the atan2 vectors, squared norm and pitch term.
// ----------------------------------------------------------------------------
module qte_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          in_valid,
   input  logic                          en,
   input  logic signed [qte_pkg::QW-1:0] quat_w,
   input  logic signed [qte_pkg::QW-1:0] quat_x,
   input  logic signed [qte_pkg::QW-1:0] quat_y,
   input  logic signed [qte_pkg::QW-1:0] quat_z,
   output logic                          out_valid,
   output qte_pkg::front_type            out_data
);

   localparam int PW = 2 * qte_pkg::QW;
   localparam int CW = qte_pkg::CW;

   logic a_valid_ff, a_en_ff, a_degen_ff;
   logic signed [PW-1:0] ww_ff, xx_ff, yy_ff, zz_ff, wx_ff;
   logic signed [PW-1:0] yz_ff, wz_ff, xy_ff, xz_ff, wy_ff;
   logic b_valid_ff;
   qte_pkg::front_type b_data_ff, b_data_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
      end
      if (advance) begin
         a_en_ff    <= en;
         a_degen_ff <= (quat_w == '0) && (quat_x == '0) && (quat_y == '0) && (quat_z == '0);
         ww_ff <= quat_w * quat_w;
         xx_ff <= quat_x * quat_x;
         yy_ff <= quat_y * quat_y;
         zz_ff <= quat_z * quat_z;
         wx_ff <= quat_w * quat_x;
         yz_ff <= quat_y * quat_z;
         wz_ff <= quat_w * quat_z;
         xy_ff <= quat_x * quat_y;
         xz_ff <= quat_x * quat_z;
         wy_ff <= quat_w * quat_y;
         b_data_ff <= b_data_in;
      end
   end

   always_comb begin
      logic signed [CW-1:0] n_sum, s, t_full;
      n_sum = CW'(ww_ff) + CW'(xx_ff) + CW'(yy_ff) + CW'(zz_ff);
      s     = a_en_ff ? n_sum : qte_pkg::ONE_CW;
      b_data_in.side.degen  = a_degen_ff;
      b_data_in.side.roll_y = (CW'(wx_ff) + CW'(yz_ff)) <<< 1;
      b_data_in.side.roll_x = s - ((CW'(xx_ff) + CW'(yy_ff)) <<< 1);
      b_data_in.side.yaw_y  = (CW'(wz_ff) + CW'(xy_ff)) <<< 1;
      b_data_in.side.yaw_x  = s - ((CW'(yy_ff) + CW'(zz_ff)) <<< 1);
      t_full = (CW'(xz_ff) - CW'(wy_ff)) <<< 1;
      b_data_in.t  = t_full[qte_pkg::TRW-1:0];
      b_data_in.n  = n_sum[qte_pkg::NW-1:0];
      b_data_in.en = a_en_ff;
   end

   assign out_valid = b_valid_ff;
   assign out_data  = b_data_ff;

endmodule

@@ hdl/qte_div.sv @@
// ----------------------------------------------------------------------------
// qte_div - pitch term normalisation
// Clamp, or restoring division of |t| by the squared norm, one bit a stage.
// ----------------------------------------------------------------------------
module qte_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          in_valid,
   input  qte_pkg::front_type            in_data,
   output logic                          out_valid,
   output qte_pkg::side_type             out_side,
   output logic signed [qte_pkg::TW-1:0] out_t
);

   localparam int NW = qte_pkg::NW;
   localparam int TW = qte_pkg::TW;
   localparam int DS = qte_pkg::DIV_STEPS;

   typedef struct packed {
      qte_pkg::side_type    side;
      logic                 fix;
      logic signed [TW-1:0] fix_t;
      logic                 neg;
      logic [NW-1:0]        n;
      logic [NW-1:0]        rem;
      logic [DS-1:0]        q;
   } div_type;

   logic    vld_ff [DS+1];
   div_type st_ff  [DS+1];
   div_type st_in  [DS+1];

   always_comb begin
      logic          tneg;
      logic [NW-1:0] mag;
      logic [NW:0]   r2;
      logic          ge;
      tneg = in_data.t < 0;
      mag  = NW'(tneg ? -in_data.t : in_data.t);
      st_in[0].side = in_data.side;
      st_in[0].neg  = tneg;
      st_in[0].n    = in_data.n;
      st_in[0].rem  = mag;
      st_in[0].q    = '0;
      st_in[0].fix  = 1'b1;
      if (!in_data.en) begin
         if (in_data.t > qte_pkg::ONE_TRW)
            st_in[0].fix_t = qte_pkg::ONE_TW;
         else if (in_data.t < -qte_pkg::ONE_TRW)
            st_in[0].fix_t = -qte_pkg::ONE_TW;
         else
            st_in[0].fix_t = TW'(in_data.t);
      end else if (in_data.n == '0) begin
         st_in[0].fix_t = '0;
      end else if (mag >= in_data.n) begin
         st_in[0].fix_t = tneg ? -qte_pkg::ONE_TW : qte_pkg::ONE_TW;
      end else begin
         st_in[0].fix   = 1'b0;
         st_in[0].fix_t = '0;
      end
      for (int i = 1; i <= DS; i++) begin
         st_in[i] = st_ff[i-1];
         r2 = {st_ff[i-1].rem, 1'b0};
         ge = r2 >= {1'b0, st_ff[i-1].n};
         st_in[i].rem = ge ? NW'(r2 - {1'b0, st_ff[i-1].n}) : NW'(r2);
         st_in[i].q   = {st_ff[i-1].q[DS-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= DS; i++) vld_ff[i] <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= in_valid;
         for (int i = 1; i <= DS; i++) vld_ff[i] <= vld_ff[i-1];
      end
      if (advance) begin
         for (int i = 0; i <= DS; i++) st_ff[i] <= st_in[i];
      end
   end

   always_comb begin
      logic signed [TW-1:0] qs;
      qs = TW'(st_ff[DS].q);
      if (st_ff[DS].fix)
         out_t = st_ff[DS].fix_t;
      else
         out_t = st_ff[DS].neg ? -qs : qs;
   end

   assign out_valid = vld_ff[DS];
   assign out_side  = st_ff[DS].side;

endmodule

@@ hdl/qte_sqrt.sv @@
// ----------------------------------------------------------------------------
// qte_sqrt - cosine leg of the pitch
// floor(sqrt(2^56 - t^2)), one root bit a stage.
// ----------------------------------------------------------------------------
module qte_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          in_valid,
   input  qte_pkg::side_type             in_side,
   input  logic signed [qte_pkg::TW-1:0] in_t,
   output logic                          out_valid,
   output qte_pkg::side_type             out_side,
   output logic signed [qte_pkg::TW-1:0] out_t,
   output logic [qte_pkg::RW-1:0]        out_c
);

   localparam int TW  = qte_pkg::TW;
   localparam int SQW = qte_pkg::SQW;
   localparam int SS  = qte_pkg::SQ_STEPS;

   typedef struct packed {
      qte_pkg::side_type    side;
      logic signed [TW-1:0] t;
      logic [SQW-1:0]       v;
      logic [SQW-1:0]       res;
   } sq_type;

   logic                 v0_ff, v1_ff;
   qte_pkg::side_type    side0_ff, side1_ff;
   logic signed [TW-1:0] t0_ff, t1_ff;
   logic [SQW-1:0]       sq1_ff;
   logic signed [2*TW-1:0] prod;
   logic   vld_ff [SS+1];
   sq_type st_ff  [SS+1];
   sq_type st_in  [SS+1];

   assign prod = t0_ff * t0_ff;

   always_comb begin
      logic [SQW-1:0] bitv, trial;
      st_in[0].side = side1_ff;
      st_in[0].t    = t1_ff;
      st_in[0].v    = (SQW'(1) << 56) - sq1_ff;
      st_in[0].res  = '0;
      for (int j = 1; j <= SS; j++) begin
         st_in[j] = st_ff[j-1];
         bitv  = SQW'(1) << (2 * (SS - j));
         trial = st_ff[j-1].res + bitv;
         if (st_ff[j-1].v >= trial) begin
            st_in[j].v   = st_ff[j-1].v - trial;
            st_in[j].res = (st_ff[j-1].res >> 1) + bitv;
         end else begin
            st_in[j].res = st_ff[j-1].res >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         for (int i = 0; i <= SS; i++) vld_ff[i] <= 1'b0;
      end else if (advance) begin
         v0_ff     <= in_valid;
         v1_ff     <= v0_ff;
         vld_ff[0] <= v1_ff;
         for (int i = 1; i <= SS; i++) vld_ff[i] <= vld_ff[i-1];
      end
      if (advance) begin
         side0_ff <= in_side;
         t0_ff    <= in_t;
         side1_ff <= side0_ff;
         t1_ff    <= t0_ff;
         sq1_ff   <= SQW'(prod);
         for (int i = 0; i <= SS; i++) st_ff[i] <= st_in[i];
      end
   end

   assign out_valid = vld_ff[SS];
   assign out_side  = st_ff[SS].side;
   assign out_t     = st_ff[SS].t;
   assign out_c     = st_ff[SS].res[qte_pkg::RW-1:0];

endmodule

@@ hdl/qte_cordic.sv @@
// ----------------------------------------------------------------------------
// qte_cordic - three-lane vectoring CORDIC and output register
// Lanes: roll, pitch, yaw. One micro-rotation a stage.
// ----------------------------------------------------------------------------
module qte_cordic (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          in_valid,
   input  qte_pkg::side_type             in_side,
   input  logic signed [qte_pkg::TW-1:0] in_t,
   input  logic [qte_pkg::RW-1:0]        in_c,
   output logic                          out_valid,
   output logic signed [qte_pkg::AW-1:0] out_roll,
   output logic signed [qte_pkg::AW-1:0] out_pitch,
   output logic signed [qte_pkg::AW-1:0] out_yaw,
   output logic                          out_degen
);

   localparam int CW = qte_pkg::CW;
   localparam int ST = qte_pkg::STEPS;

   logic             vld_ff   [ST+1];
   logic             degen_ff [ST+1];
   qte_pkg::vec_type lane_ff  [ST+1][3];
   qte_pkg::vec_type lane_in  [ST+1][3];
   logic                          out_valid_ff, out_degen_ff;
   logic signed [qte_pkg::AW-1:0] out_roll_ff, out_pitch_ff, out_yaw_ff;

   function automatic qte_pkg::vec_type prerotate(input logic signed [CW-1:0] x,
                                                  input logic signed [CW-1:0] y);
      qte_pkg::vec_type v;
      v.zero = (x == '0) && (y == '0);
      v.x    = (x < 0) ? -x : x;
      v.y    = (x < 0) ? -y : y;
      v.ang  = (x < 0) ? qte_pkg::ANG_PI : 32'd0;
      return v;
   endfunction

   function automatic qte_pkg::vec_type rotate(input qte_pkg::vec_type v,
                                               input logic [4:0] s);
      qte_pkg::vec_type r;
      logic signed [CW-1:0] dx, dy;
      dx = v.y >>> s;
      dy = v.x >>> s;
      r  = v;
      if (v.y >= 0) begin
         r.x   = v.x + dx;
         r.y   = v.y - dy;
         r.ang = v.ang + qte_pkg::atan_entry(s);
      end else begin
         r.x   = v.x - dx;
         r.y   = v.y + dy;
         r.ang = v.ang - qte_pkg::atan_entry(s);
      end
      return r;
   endfunction

   always_comb begin
      lane_in[0][0] = prerotate(in_side.roll_x, in_side.roll_y);
      lane_in[0][1] = prerotate(CW'(in_c), CW'(in_t));
      lane_in[0][2] = prerotate(in_side.yaw_x, in_side.yaw_y);
      for (int i = 1; i <= ST; i++)
         for (int l = 0; l < 3; l++)
            lane_in[i][l] = rotate(lane_ff[i-1][l], 5'(i - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= ST; i++) vld_ff[i] <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= in_valid;
         for (int i = 1; i <= ST; i++) vld_ff[i] <= vld_ff[i-1];
         out_valid_ff <= vld_ff[ST];
      end
      if (advance) begin
         degen_ff[0] <= in_side.degen;
         for (int i = 1; i <= ST; i++) degen_ff[i] <= degen_ff[i-1];
         for (int i = 0; i <= ST; i++)
            for (int l = 0; l < 3; l++)
               lane_ff[i][l] <= lane_in[i][l];
         // zero vector or all-zero quaternion gives angle 0
         out_degen_ff <= degen_ff[ST];
         out_roll_ff  <= (degen_ff[ST] || lane_ff[ST][0].zero) ? '0 :
                         qte_pkg::round_angle(lane_ff[ST][0].ang);
         out_pitch_ff <= (degen_ff[ST] || lane_ff[ST][1].zero) ? '0 :
                         qte_pkg::round_angle(32'd0 - lane_ff[ST][1].ang);
         out_yaw_ff   <= (degen_ff[ST] || lane_ff[ST][2].zero) ? '0 :
                         qte_pkg::round_angle(lane_ff[ST][2].ang);
      end
   end

   assign out_valid = out_valid_ff;
   assign out_degen = out_degen_ff;
   assign out_roll  = out_roll_ff;
   assign out_pitch = out_pitch_ff;
   assign out_yaw   = out_yaw_ff;

endmodule

@@ hdl/quaternion_to_euler_angles_core.sv @@
// Throughput: one request per cycle; every stage moves on each clock unless a
//   response waits in the output register, which then holds the whole pipeline.
// Reset: synchronous, active high; clears all valid bits and sets
//   normalize_enable to 1. No clearing pass, usable the cycle after reset.
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_core - Z-Y-X Euler angles from a quaternion
// Roll and yaw by atan2, pitch by -asin of the clamped term 2(xz-wy), all as
// 16-bit binary angles (32768 = pi), using fixed-length CORDIC.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles_core (
   input  logic                          clock,
   input  logic                          reset,
   // configuration
   input  logic                          csr_wr_en,
   input  logic                          csr_wr_data,
   // request channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [qte_pkg::QW-1:0] req_quat_w,
   input  logic signed [qte_pkg::QW-1:0] req_quat_x,
   input  logic signed [qte_pkg::QW-1:0] req_quat_y,
   input  logic signed [qte_pkg::QW-1:0] req_quat_z,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [qte_pkg::AW-1:0] rsp_roll_angle,
   output logic signed [qte_pkg::AW-1:0] rsp_pitch_angle,
   output logic signed [qte_pkg::AW-1:0] rsp_yaw_angle,
   output logic                          rsp_degenerate
);

   // Pipeline map:
   //   front   products, then norm / atan2 vectors / pitch term
   //   div     clamp or |t|*2^28/n, one quotient bit a stage
   //   sqrt    t^2, 2^56-t^2, then one root bit a stage
   //   cordic  pre-rotation, 16 micro-rotations, rounding + output reg

   logic normalize_enable_ff;
   logic advance;

   logic                          front_valid;
   qte_pkg::front_type            front_data;
   logic                          div_valid;
   qte_pkg::side_type             div_side;
   logic signed [qte_pkg::TW-1:0] div_t;
   logic                          sqrt_valid;
   qte_pkg::side_type             sqrt_side;
   logic signed [qte_pkg::TW-1:0] sqrt_t;
   logic [qte_pkg::RW-1:0]        sqrt_c;

   // Whole pipeline moves unless a finished response is being held.
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   always_ff @(posedge clock) begin
      if (reset)
         normalize_enable_ff <= 1'b1;
      else if (csr_wr_en)
         normalize_enable_ff <= csr_wr_data;
   end

   qte_front u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .en        (normalize_enable_ff),
      .quat_w    (req_quat_w),
      .quat_x    (req_quat_x),
      .quat_y    (req_quat_y),
      .quat_z    (req_quat_z),
      .out_valid (front_valid),
      .out_data  (front_data)
   );

   qte_div u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (front_valid),
      .in_data   (front_data),
      .out_valid (div_valid),
      .out_side  (div_side),
      .out_t     (div_t)
   );

   qte_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (div_valid),
      .in_side   (div_side),
      .in_t      (div_t),
      .out_valid (sqrt_valid),
      .out_side  (sqrt_side),
      .out_t     (sqrt_t),
      .out_c     (sqrt_c)
   );

   qte_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (sqrt_valid),
      .in_side   (sqrt_side),
      .in_t      (sqrt_t),
      .in_c      (sqrt_c),
      .out_valid (rsp_valid),
      .out_roll  (rsp_roll_angle),
      .out_pitch (rsp_pitch_angle),
      .out_yaw   (rsp_yaw_angle),
      .out_degen (rsp_degenerate)
   );

endmodule

@@ hdl/qte_checker.sv @@
// ----------------------------------------------------------------------------
// qte_checker - port-level checks
// Reset, stall and degenerate-response properties, bound to the core.
// ----------------------------------------------------------------------------
module qte_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic signed [qte_pkg::AW-1:0] rsp_roll_angle,
   input logic signed [qte_pkg::AW-1:0] rsp_pitch_angle,
   input logic signed [qte_pkg::AW-1:0] rsp_yaw_angle,
   input logic                          rsp_degenerate
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_roll_angle)
         && $stable(rsp_pitch_angle) && $stable(rsp_yaw_angle))
      else $error("stalled response changed");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while pipeline stalled");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_roll_angle == '0
         && rsp_pitch_angle == '0 && rsp_yaw_angle == '0)
      else $error("degenerate response with non-zero angle");

endmodule

bind quaternion_to_euler_angles_core qte_checker u_qte_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_roll_angle  (rsp_roll_angle),
   .rsp_pitch_angle (rsp_pitch_angle),
   .rsp_yaw_angle   (rsp_yaw_angle),
   .rsp_degenerate  (rsp_degenerate)
);

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - quaternion to Euler angles core bench
// Drives quaternions through the request channel in both normalising modes,
// predicts roll, pitch and yaw with a bit-true CORDIC model and compares
// each response in order. Random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module tb;

   localparam int LATENCY = 81;

   typedef struct packed {
      logic signed [qte_pkg::QW-1:0] w, x, y, z;
   } quat_type;

   typedef struct packed {
      logic signed [qte_pkg::AW-1:0] roll, pitch, yaw;
      logic                          degen;
   } euler_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0, csr_wr_data = 1'b0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [qte_pkg::QW-1:0] req_quat_w = '0, req_quat_x = '0;
   logic signed [qte_pkg::QW-1:0] req_quat_y = '0, req_quat_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [qte_pkg::AW-1:0] rsp_roll_angle, rsp_pitch_angle, rsp_yaw_angle;
   logic rsp_degenerate;

   quaternion_to_euler_angles_core dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // bench copy of the mode register
   bit        norm_mode = 1'b1;
   euler_type angles_due[$];
   int        fault_count = 0;
   int        rsp_count = 0;
   int        hold_off = 0;    // receiver hold-off in cycles
   bit        rsp_stall_en = 1'b1;

   // ---------------------------------------------------------------- model
   function automatic logic [31:0] atan_of(input int i);
      logic [31:0] tab [32] = '{
         32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
         32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
         32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
         32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
         32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
         32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
         32'h00000001, 32'h00000000};
      return tab[i];
   endfunction

   function automatic logic [31:0] vector_angle(input longint yv, input longint xv);
      logic [31:0] acc;
      longint dx, dy;
      acc = '0;
      if (xv == 0 && yv == 0) return '0;
      if (xv < 0) begin
         xv = -xv; yv = -yv; acc = qte_pkg::ANG_PI;
      end
      for (int i = 0; i < qte_pkg::STEPS; i++) begin
         dx = yv >>> i;
         dy = xv >>> i;
         if (yv >= 0) begin
            xv += dx; yv -= dy; acc += atan_of(i);
         end else begin
            xv -= dx; yv += dy; acc -= atan_of(i);
         end
      end
      return acc;
   endfunction

   function automatic logic [qte_pkg::AW-1:0] to_binary_angle(input logic [31:0] a);
      logic [31:0] s;
      s = a + (32'd1 << (31 - qte_pkg::AW));
      return s[31 -: qte_pkg::AW];
   endfunction

   function automatic longint floor_sqrt(input longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b; res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return longint'(res);
   endfunction

   function automatic euler_type predict_angles(input quat_type q, input bit nm);
      euler_type r;
      longint w, x, y, z, n, s, t, ry, rx, yy, yx, c;
      longint unsigned mag, quo;
      w = q.w; x = q.x; y = q.y; z = q.z;
      if (q == '0) begin
         r = '0; r.degen = 1'b1; return r;
      end
      // Q2.14 products are already Q.28
      n  = w*w + x*x + y*y + z*z;
      s  = nm ? n : 64'sd1 <<< 28;
      ry = 2 * (w*x + y*z);
      rx = s - 2 * (x*x + y*y);
      yy = 2 * (w*z + x*y);
      yx = s - 2 * (y*y + z*z);
      t  = 2 * (x*z - w*y);
      if (nm) begin
         if (n <= 0) t = 0;
         else begin
            mag = t < 0 ? -t : t;
            if (mag > (64'd1 << 34)) mag = 64'd1 << 34;
            quo = (mag << 28) / longint'(n);
            if (quo > (64'd1 << 28)) quo = 64'd1 << 28;
            t = t < 0 ? -longint'(quo) : longint'(quo);
         end
      end
      if (t > (64'sd1 <<< 28)) t = 64'sd1 <<< 28;
      if (t < -(64'sd1 <<< 28)) t = -(64'sd1 <<< 28);
      c = floor_sqrt((64'd1 << 56) - longint'(t * t));
      r.roll  = to_binary_angle(vector_angle(ry, rx));
      r.pitch = to_binary_angle(32'd0 - vector_angle(t, c));
      r.yaw   = to_binary_angle(vector_angle(yy, yx));
      r.degen = 1'b0;
      return r;
   endfunction

   // ---------------------------------------------------------------- helpers
   task automatic report_mismatch(input string what, input int got, input int want);
      fault_count++;
      $display("[%0t] MISMATCH %s: got %0d want %0d", $realtime, what, got, want);
   endtask

   function automatic int short_gap();
      return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
           : ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
   endfunction

   // entered at a falling edge; valid stays up between back-to-back requests
   task automatic send_quat(input quat_type q, input bit gaps);
      int g;
      g = gaps ? short_gap() : 0;
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_quat_w <= q.w; req_quat_x <= q.x; req_quat_y <= q.y; req_quat_z <= q.z;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      angles_due.push_back(predict_angles(q, norm_mode));
      @(negedge clock);
   endtask

   task automatic drain_requests();
      req_valid <= 1'b0;
      while (angles_due.size() != 0) @(negedge clock);
      // let anything still in flight clear before touching the register
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   task automatic write_mode(input bit m);
      csr_wr_en <= 1'b1; csr_wr_data <= m;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      norm_mode = m;
   endtask

   function automatic quat_type random_quat();
      quat_type q;
      int k;
      k = $urandom_range(0, 9);
      q = quat_type'({$urandom, $urandom});
      if (k < 5) begin
         // unit-range components: each within -1 to just under 1 in Q2.14
         q.w = $signed(16'($urandom_range(0, 32767))) - 16'sd16384;
         q.x = $signed(16'($urandom_range(0, 32767))) - 16'sd16384;
         q.y = $signed(16'($urandom_range(0, 32767))) - 16'sd16384;
         q.z = $signed(16'($urandom_range(0, 32767))) - 16'sd16384;
      end else if (k == 5) begin
         // small magnitudes
         q.w = $signed(16'($urandom_range(0, 15))) - 16'sd8;
         q.x = $signed(16'($urandom_range(0, 15))) - 16'sd8;
         q.y = $signed(16'($urandom_range(0, 15))) - 16'sd8;
         q.z = $signed(16'($urandom_range(0, 15))) - 16'sd8;
      end else if (k == 6) begin
         // gimbal lock region: x*z - w*y near +/- one half
         q.w = 16'sd11585; q.y = $urandom_range(0, 1) ? 16'sd11585 : -16'sd11585;
         q.x = $signed(16'($urandom_range(0, 63))) - 16'sd32;
         q.z = $signed(16'($urandom_range(0, 63))) - 16'sd32;
      end else if (k == 7 && $urandom_range(0, 3) == 0) begin
         q = '0;
      end
      return q;
   endfunction

   // ---------------------------------------------------------------- checker
   always @(posedge clock) begin
      euler_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_count++;
         if (angles_due.size() == 0) begin
            fault_count++;
            $display("[%0t] MISMATCH unexpected response", $realtime);
         end else begin
            e = angles_due.pop_front();
            if (rsp_roll_angle !== e.roll)   report_mismatch("roll", rsp_roll_angle, e.roll);
            if (rsp_pitch_angle !== e.pitch) report_mismatch("pitch", rsp_pitch_angle, e.pitch);
            if (rsp_yaw_angle !== e.yaw)     report_mismatch("yaw", rsp_yaw_angle, e.yaw);
            if (rsp_degenerate !== e.degen)  report_mismatch("degenerate", rsp_degenerate, e.degen);
         end
      end
   end

   // receiver back-pressure, with a long hold-off when asked for
   always @(negedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_ready <= 1'b0;
      end else if (!rsp_stall_en) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(0, 3) != 0);
      end
   end

   // ---------------------------------------------------------------- tests
   task automatic test_directed(input bit m);
      quat_type list [$];
      list = '{'0, '{16'sd16384, 0, 0, 0}, '{-16'sd16384, 0, 0, 0},
               '{0, 16'sd16384, 0, 0}, '{0, 0, 16'sd16384, 0}, '{0, 0, 0, 16'sd16384},
               '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767},
               '{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768},
               '{-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767},
               '{16'sd11585, 0, 16'sd11585, 0}, '{16'sd11585, 0, -16'sd11585, 0},
               '{16'sd16384, 0, 16'sd16384, 0}, '{0, 16'sd16384, 0, 16'sd16384},
               '{0, 16'sd1, 0, 0}, '{16'sd1, 0, 0, 0}, '{-16'sd1, -16'sd1, 16'sd1, -16'sd1},
               '{0, 0, 16'sd23170, 16'sd23170}, '{16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192},
               '{16'sd5, -16'sd32768, 16'sd32767, 16'sd3}};
      foreach (list[i]) send_quat(list[i], 1'b0);
      drain_requests();
   endtask

   task automatic test_random(input int count);
      for (int i = 0; i < count; i++) send_quat(random_quat(), 1'b1);
      drain_requests();
   endtask

   task automatic test_backpressure();
      hold_off = 200;
      // sender keeps offering while the response side is held off
      for (int i = 0; i < 150; i++) send_quat(random_quat(), 1'b0);
      drain_requests();
   endtask

   task automatic test_full_rate();
      rsp_stall_en = 1'b0;
      for (int i = 0; i < 200; i++) send_quat(random_quat(), 1'b0);
      drain_requests();
      rsp_stall_en = 1'b1;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed(1'b1);      // reset mode: normalising
      write_mode(1'b0);
      test_directed(1'b0);
      test_random(400);
      write_mode(1'b1);
      test_random(400);
      test_backpressure();
      write_mode(1'b0);
      test_full_rate();
      test_backpressure();
      write_mode(1'b1);
      test_random(300);
      $display("Run covered %0d responses in both normalising modes, with extremes,",
               rsp_count);
      $display("zero quaternion, gimbal lock terms, stalls and full-rate streaming.");
      if (fault_count == 0 && angles_due.size() == 0)
         $display("quaternion_to_euler_angles_core verification clean");
      else
         $display("quaternion_to_euler_angles_core verification failed");
      $finish;
   end

   initial begin
      #4000000;
      $display("quaternion_to_euler_angles_core verification failed");
      $finish;
   end

endmodule

@@ files.f @@
hdl/qte_pkg.sv
hdl/qte_front.sv
hdl/qte_div.sv
hdl/qte_sqrt.sv
hdl/qte_cordic.sv
hdl/quaternion_to_euler_angles_core.sv
hdl/qte_checker.sv
bench/tb.sv
